// ===== src/evpm_pkg.sv =====
// Shared constants, command and register codes, and colour helpers for the
// event pixel map. Depends on nothing; used by the top level and its testbench.
package evpm_pkg;

    // Grid and word sizes. The grid side is a power of two.
    localparam int GRID_SIDE    = 128;
    localparam int TIME_BITS    = 32;
    localparam int CHANNEL_BITS = 8;

    localparam int COORD_BITS = $clog2(GRID_SIDE);
    localparam int ADDR_BITS  = 2 * COORD_BITS;
    localparam int CELLS      = GRID_SIDE * GRID_SIDE;
    localparam int COLOR_BITS = 3 * CHANNEL_BITS;

    // Fixed port widths.
    localparam int POS_BITS       = 7;
    localparam int STAMP_BITS     = 32;
    localparam int OUT_CHAN_BITS  = 8;
    localparam int CMD_BITS       = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int REFR_BITS      = 32;
    localparam int STEP_BITS      = 8;
    localparam int CFG_COLOR_BITS = 24;

    // Widths for the refractory compare and the decay arithmetic.
    localparam int GAP_BITS = (TIME_BITS > REFR_BITS) ? TIME_BITS : REFR_BITS;
    localparam int SUM_BITS = ((CHANNEL_BITS > STEP_BITS) ? CHANNEL_BITS : STEP_BITS) + 1;

    typedef logic [COLOR_BITS-1:0]   t_color;
    typedef logic [CHANNEL_BITS-1:0] t_chan;
    typedef logic [ADDR_BITS-1:0]    t_addr;
    typedef logic [TIME_BITS-1:0]    t_time;

    // Command codes.
    localparam logic [CMD_BITS-1:0] CMD_EVENT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_DECAY = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REFRACTORY = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY_STEP = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ON_COLOR   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OFF_COLOR  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MID_COLOR  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FLIP       = 3'd5;

    // Register values after reset.
    localparam logic [REFR_BITS-1:0]      RST_REFRACTORY = 32'd0;
    localparam logic [STEP_BITS-1:0]      RST_DECAY_STEP = 8'd4;
    localparam logic [CFG_COLOR_BITS-1:0] RST_ON_COLOR   = 24'hFFFFFF;
    localparam logic [CFG_COLOR_BITS-1:0] RST_OFF_COLOR  = 24'h000000;
    localparam logic [CFG_COLOR_BITS-1:0] RST_MID_COLOR  = 24'h808080;
    localparam logic                      RST_FLIP       = 1'b1;

    // Channel k of a packed colour, red being channel 0 at the top.
    function automatic t_chan chan_of(input t_color packed_color, input int k);
        chan_of = packed_color[(2 - k) * CHANNEL_BITS +: CHANNEL_BITS];
    endfunction

    // Moves one channel towards its target by step, landing on the target
    // when it lies within one step.
    function automatic t_chan decay_chan(input t_chan cur, input t_chan target,
                                         input logic [STEP_BITS-1:0] step);
        logic [SUM_BITS-1:0] cur_w;
        logic [SUM_BITS-1:0] tgt_w;
        logic [SUM_BITS-1:0] stp_w;
        cur_w = SUM_BITS'(cur);
        tgt_w = SUM_BITS'(target);
        stp_w = SUM_BITS'(step);
        if (cur_w >= tgt_w + stp_w) begin
            decay_chan = CHANNEL_BITS'(cur_w - stp_w);
        end else if (cur_w + stp_w <= tgt_w) begin
            decay_chan = CHANNEL_BITS'(cur_w + stp_w);
        end else begin
            decay_chan = target;
        end
    endfunction

    // Applies one decay step to all three channels of a pixel.
    function automatic t_color decay_pixel(input t_color pix, input t_color mid,
                                           input logic [STEP_BITS-1:0] step);
        t_color res;
        res = '0;
        for (int k = 0; k < 3; k++) begin
            res[(2 - k) * CHANNEL_BITS +: CHANNEL_BITS] =
                decay_chan(chan_of(pix, k), chan_of(mid, k), step);
        end
        decay_pixel = res;
    endfunction

endpackage

// ===== src/event_pixel_map_with_refractory_decay_top.sv =====
// Event pixel map: colour and last-event time memories with the command sequencer.
// Depends on evpm_pkg for sizes, codes and the decay arithmetic.
//
// The block holds a 128 x 128 map of pixel colours and the time of each pixel's
// last accepted event in two synchronous memories with separate read and write
// ports. Every command returns exactly one result: the colour of the addressed
// pixel after the command and, for an event, whether it passed the refractory
// test. For an event or a read the memory is read at the accepting edge; compare,
// write back and the result register follow at the next edge once the result
// slot is free. A decay pass walks every pixel through a read-modify-write at one
// pixel a cycle; a clear writes one pixel a cycle. After reset a clearing pass
// zeroes both memories, during which no request is accepted; configuration
// writes are taken at any time. The block works on one request at a time and
// holds i_in_valid off with o_in_stall while busy; a finished result waits in an
// output register, so the next request may be accepted before it is taken.
// Configuration should only be written while no request is in progress, and a
// clear should follow configuration.
module event_pixel_map_with_refractory_decay_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [evpm_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [evpm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,

    // Request channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [evpm_pkg::CMD_BITS-1:0]        i_cmd,
    input  logic [evpm_pkg::POS_BITS-1:0]        i_pos_x,
    input  logic [evpm_pkg::POS_BITS-1:0]        i_pos_y,
    input  logic                                 i_polarity,
    input  logic [evpm_pkg::STAMP_BITS-1:0]      i_timestamp,

    // Result channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [evpm_pkg::OUT_CHAN_BITS-1:0]   o_red,
    output logic [evpm_pkg::OUT_CHAN_BITS-1:0]   o_green,
    output logic [evpm_pkg::OUT_CHAN_BITS-1:0]   o_blue,
    output logic                                 o_accepted
);

    // Sequencer states.
    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECAY  = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_CLEAR  = 3'd4;
    localparam logic [2:0] ST_LOOKUP = 3'd5;
    localparam logic [2:0] ST_RESULT = 3'd6;

    localparam evpm_pkg::t_addr LAST_ADDR = evpm_pkg::ADDR_BITS'(evpm_pkg::CELLS - 1);

    // Configuration registers.
    logic [evpm_pkg::REFR_BITS-1:0]      r_refractory;
    logic [evpm_pkg::STEP_BITS-1:0]      r_decay_step;
    logic [evpm_pkg::CFG_COLOR_BITS-1:0] r_on_color;
    logic [evpm_pkg::CFG_COLOR_BITS-1:0] r_off_color;
    logic [evpm_pkg::CFG_COLOR_BITS-1:0] r_mid_color;
    logic                                r_flip;

    // Control state.
    logic [2:0]      r_state;
    logic [2:0]      n_state;
    evpm_pkg::t_addr r_sweep;
    evpm_pkg::t_addr n_sweep;
    logic            r_wb_valid;
    logic            n_wb_valid;
    logic            r_out_valid;
    logic            n_out_valid;

    // Request payload held for the duration of the command.
    logic [evpm_pkg::CMD_BITS-1:0] r_cmd;
    evpm_pkg::t_addr               r_idx;
    logic                          r_pol;
    evpm_pkg::t_time               r_ts;
    evpm_pkg::t_addr               r_wb_addr;

    // Memories and their registered read data.
    evpm_pkg::t_color mem_color [evpm_pkg::CELLS];
    evpm_pkg::t_time  mem_time  [evpm_pkg::CELLS];
    evpm_pkg::t_color r_rd_color;
    evpm_pkg::t_time  r_rd_time;

    // Output register.
    logic [evpm_pkg::OUT_CHAN_BITS-1:0] r_red;
    logic [evpm_pkg::OUT_CHAN_BITS-1:0] r_green;
    logic [evpm_pkg::OUT_CHAN_BITS-1:0] r_blue;
    logic                               r_accepted;

    logic                               in_accept;
    logic                               out_free;
    logic [evpm_pkg::COORD_BITS-1:0]    x_c;
    logic [evpm_pkg::COORD_BITS-1:0]    y_c;
    evpm_pkg::t_addr                    in_idx;
    evpm_pkg::t_addr                    rd_addr;
    logic [evpm_pkg::TIME_BITS-1:0]     gap;
    logic                               event_ok;
    evpm_pkg::t_color                   event_color;
    evpm_pkg::t_color                   result_color;
    logic                               color_we;
    logic                               time_we;
    evpm_pkg::t_addr                    wr_addr;
    evpm_pkg::t_color                   wr_color;
    evpm_pkg::t_time                    wr_time;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Pixel address: coordinates wrap to the grid, then the optional row flip.
    assign x_c    = evpm_pkg::COORD_BITS'(i_pos_x);
    assign y_c    = r_flip ? ~evpm_pkg::COORD_BITS'(i_pos_y) : evpm_pkg::COORD_BITS'(i_pos_y);
    assign in_idx = {x_c, y_c};

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refractory <= evpm_pkg::RST_REFRACTORY;
            r_decay_step <= evpm_pkg::RST_DECAY_STEP;
            r_on_color   <= evpm_pkg::RST_ON_COLOR;
            r_off_color  <= evpm_pkg::RST_OFF_COLOR;
            r_mid_color  <= evpm_pkg::RST_MID_COLOR;
            r_flip       <= evpm_pkg::RST_FLIP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                evpm_pkg::CFG_REFRACTORY: r_refractory <= evpm_pkg::REFR_BITS'(i_cfg_data);
                evpm_pkg::CFG_DECAY_STEP: r_decay_step <= evpm_pkg::STEP_BITS'(i_cfg_data);
                evpm_pkg::CFG_ON_COLOR:   r_on_color   <= evpm_pkg::CFG_COLOR_BITS'(i_cfg_data);
                evpm_pkg::CFG_OFF_COLOR:  r_off_color  <= evpm_pkg::CFG_COLOR_BITS'(i_cfg_data);
                evpm_pkg::CFG_MID_COLOR:  r_mid_color  <= evpm_pkg::CFG_COLOR_BITS'(i_cfg_data);
                evpm_pkg::CFG_FLIP:       r_flip       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Refractory test and the colour that the result reports.
    assign gap         = r_ts - r_rd_time;
    assign event_ok    = (r_cmd == evpm_pkg::CMD_EVENT) &&
                         (evpm_pkg::GAP_BITS'(gap) > evpm_pkg::GAP_BITS'(r_refractory));
    assign event_color = evpm_pkg::COLOR_BITS'(r_pol ? r_on_color : r_off_color);
    assign result_color = event_ok ? event_color : r_rd_color;

    // Memory read address: the incoming request when idle, the sweep during a
    // decay pass, and the held pixel otherwise.
    always_comb begin
        unique case (r_state)
            ST_IDLE:  rd_addr = in_idx;
            ST_DECAY: rd_addr = r_sweep;
            default:  rd_addr = r_idx;
        endcase
    end

    // Memory write port: clearing sweeps, decay write-back, event update.
    always_comb begin
        color_we = 1'b0;
        time_we  = 1'b0;
        wr_addr  = r_sweep;
        wr_color = '0;
        wr_time  = '0;
        priority if (r_state == ST_INIT || r_state == ST_CLEAR) begin
            color_we = 1'b1;
            time_we  = 1'b1;
            wr_color = (r_state == ST_CLEAR) ? evpm_pkg::COLOR_BITS'(r_mid_color) : '0;
        end else if (r_wb_valid) begin
            color_we = 1'b1;
            wr_addr  = r_wb_addr;
            wr_color = evpm_pkg::decay_pixel(r_rd_color,
                                             evpm_pkg::COLOR_BITS'(r_mid_color),
                                             r_decay_step);
        end else if (r_state == ST_RESULT && out_free && event_ok) begin
            color_we = 1'b1;
            time_we  = 1'b1;
            wr_addr  = r_idx;
            wr_color = event_color;
            wr_time  = r_ts;
        end else begin
            color_we = 1'b0;
        end
    end

    // Colour memory.
    always_ff @(posedge i_clk) begin
        if (color_we) begin
            mem_color[wr_addr] <= wr_color;
        end
        r_rd_color <= mem_color[rd_addr];
    end

    // Time memory.
    always_ff @(posedge i_clk) begin
        if (time_we) begin
            mem_time[wr_addr] <= wr_time;
        end
        r_rd_time <= mem_time[rd_addr];
    end

    // Sequencer next state.
    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_wb_valid  = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_INIT: begin
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_sweep = '0;
                    unique case (i_cmd)
                        evpm_pkg::CMD_DECAY: n_state = ST_DECAY;
                        evpm_pkg::CMD_CLEAR: n_state = ST_CLEAR;
                        evpm_pkg::CMD_EVENT,
                        evpm_pkg::CMD_READ:  n_state = ST_RESULT;
                    endcase
                end
            end
            ST_DECAY: begin
                n_wb_valid = 1'b1;
                n_sweep    = r_sweep + 1'b1;
                if (r_sweep == LAST_ADDR) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_LOOKUP;
            end
            ST_CLEAR: begin
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == LAST_ADDR) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_sweep     <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_wb_valid  <= n_wb_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Request payload and decay write-back address.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd <= i_cmd;
            r_idx <= in_idx;
            r_pol <= i_polarity;
            r_ts  <= evpm_pkg::TIME_BITS'(i_timestamp);
        end
        r_wb_addr <= r_sweep;
    end

    // Result register, loaded when the result slot is free.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESULT && out_free) begin
            r_red      <= evpm_pkg::OUT_CHAN_BITS'(evpm_pkg::chan_of(result_color, 0));
            r_green    <= evpm_pkg::OUT_CHAN_BITS'(evpm_pkg::chan_of(result_color, 1));
            r_blue     <= evpm_pkg::OUT_CHAN_BITS'(evpm_pkg::chan_of(result_color, 2));
            r_accepted <= event_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_accepted  = r_accepted;

endmodule

// ===== verif/tb_event_pixel_map_with_refractory_decay_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the event pixel map top level: it drives requests and
// register writes, keeps its own copy of the colour and time maps, and checks every result.
// Depends on evpm_pkg and event_pixel_map_with_refractory_decay_top.
module tb_event_pixel_map_with_refractory_decay_top;
    import evpm_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int STALL_LIMIT   = 100000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 400;
    localparam int MAX_PASSES    = 24;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [CFG_INDEX_BITS-1:0]   i_cfg_index;
    logic [CFG_DATA_BITS-1:0]    i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic [CMD_BITS-1:0]         i_cmd;
    logic [POS_BITS-1:0]         i_pos_x;
    logic [POS_BITS-1:0]         i_pos_y;
    logic                        i_polarity;
    logic [STAMP_BITS-1:0]       i_timestamp;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [OUT_CHAN_BITS-1:0]    o_red;
    logic [OUT_CHAN_BITS-1:0]    o_green;
    logic [OUT_CHAN_BITS-1:0]    o_blue;
    logic                        o_accepted;

    // One result: the addressed pixel's colour and the refractory verdict.
    typedef struct packed {
        logic [OUT_CHAN_BITS-1:0] red;
        logic [OUT_CHAN_BITS-1:0] green;
        logic [OUT_CHAN_BITS-1:0] blue;
        logic                     accepted;
    } t_pixel_result;

    t_pixel_result expected_pixels[$];

    // Predicted map contents and register values.
    t_color               color_map [CELLS];
    t_time                stamp_map [CELLS];
    logic [REFR_BITS-1:0] refr_gap;
    logic [STEP_BITS-1:0] step_size;
    t_color               on_rgb;
    t_color               off_rgb;
    t_color               rest_rgb;
    logic                 flip_rows;

    int error_count  = 0;
    int idle_cycles  = 0;
    bit req_idle_on  = 1'b0;
    bit resp_idle_on = 1'b0;
    bit hold_off_req = 1'b0;

    event_pixel_map_with_refractory_decay_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_polarity  (i_polarity),
        .i_timestamp (i_timestamp),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_accepted  (o_accepted)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Moves one channel towards its resting value, stopping on it when within a step.
    function automatic logic [CHANNEL_BITS-1:0] approach_rest(int cur, int tgt, int stp);
        if (cur - stp >= tgt) return CHANNEL_BITS'(cur - stp);
        if (cur + stp <= tgt) return CHANNEL_BITS'(cur + stp);
        return CHANNEL_BITS'(tgt);
    endfunction

    function automatic t_color faded(t_color pix);
        t_color res;
        res = pix;
        for (int k = 0; k < 3; k++) begin
            res[k*CHANNEL_BITS +: CHANNEL_BITS] =
                approach_rest(int'(pix[k*CHANNEL_BITS +: CHANNEL_BITS]),
                              int'(rest_rgb[k*CHANNEL_BITS +: CHANNEL_BITS]),
                              int'(step_size));
        end
        return res;
    endfunction

    // Applies one request to the predicted maps and returns the result it should give.
    function automatic t_pixel_result pixel_after_request(logic [CMD_BITS-1:0] cmd,
                                                          logic [POS_BITS-1:0] px,
                                                          logic [POS_BITS-1:0] py,
                                                          logic pol, t_time ts);
        int unsigned   row;
        int unsigned   addr;
        t_time         gap;
        t_pixel_result res;
        row = flip_rows ? (GRID_SIDE - 1 - int'(py)) : int'(py);
        addr = int'(px) * GRID_SIDE + row;
        res.accepted = 1'b0;
        case (cmd)
            CMD_EVENT: begin
                // Modulo subtraction handles a wrapped timestamp.
                gap = ts - stamp_map[addr];
                if (gap > refr_gap) begin
                    color_map[addr] = pol ? on_rgb : off_rgb;
                    stamp_map[addr] = ts;
                    res.accepted = 1'b1;
                end
            end
            CMD_DECAY: begin
                for (int i = 0; i < CELLS; i++) color_map[i] = faded(color_map[i]);
            end
            CMD_CLEAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    color_map[i] = rest_rgb;
                    stamp_map[i] = '0;
                end
            end
            default: ;
        endcase
        res.red   = color_map[addr][2*CHANNEL_BITS +: CHANNEL_BITS];
        res.green = color_map[addr][CHANNEL_BITS +: CHANNEL_BITS];
        res.blue  = color_map[addr][0 +: CHANNEL_BITS];
        return res;
    endfunction

    // Offers one request after an optional gap and records its prediction once taken.
    task automatic send_request(logic [CMD_BITS-1:0] cmd, logic [POS_BITS-1:0] px,
                                logic [POS_BITS-1:0] py, logic pol, t_time ts);
        int            gap;
        t_pixel_result predicted;
        gap = req_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_pos_x     <= px;
        i_pos_y     <= py;
        i_polarity  <= pol;
        i_timestamp <= ts;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = pixel_after_request(cmd, px, py, pol, ts);
        expected_pixels.insert(expected_pixels.size(), predicted);
    endtask

    // Stops offering and waits until every outstanding result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_REFRACTORY: refr_gap  = val[REFR_BITS-1:0];
            CFG_DECAY_STEP: step_size = val[STEP_BITS-1:0];
            CFG_ON_COLOR:   on_rgb    = val[COLOR_BITS-1:0];
            CFG_OFF_COLOR:  off_rgb   = val[COLOR_BITS-1:0];
            CFG_MID_COLOR:  rest_rgb  = val[COLOR_BITS-1:0];
            CFG_FLIP:       flip_rows = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Writes every register while idle, then clears the map as the block requires.
    task automatic configure(logic [REFR_BITS-1:0] refr, logic [STEP_BITS-1:0] step,
                             t_color on_c, t_color off_c, t_color mid_c, logic flip);
        drain_results();
        write_reg(CFG_REFRACTORY, CFG_DATA_BITS'(refr));
        write_reg(CFG_DECAY_STEP, CFG_DATA_BITS'(step));
        write_reg(CFG_ON_COLOR, CFG_DATA_BITS'(on_c));
        write_reg(CFG_OFF_COLOR, CFG_DATA_BITS'(off_c));
        write_reg(CFG_MID_COLOR, CFG_DATA_BITS'(mid_c));
        write_reg(CFG_FLIP, CFG_DATA_BITS'(flip));
        send_request(CMD_CLEAR, '0, '0, 1'b0, '0);
    endtask

    // Reset colours and times, the untouched pixel and a wrapping timestamp.
    task automatic test_before_clear();
        req_idle_on  = 1'b0;
        resp_idle_on = 1'b0;
        send_request(CMD_READ, 7'd0, 7'd0, 1'b0, 32'd0);
        // An untouched pixel holds time zero, so an event at zero is refused.
        send_request(CMD_EVENT, 7'd0, 7'd0, 1'b1, 32'd0);
        send_request(CMD_EVENT, 7'd127, 7'd127, 1'b1, 32'd1);
        send_request(CMD_EVENT, 7'd127, 7'd127, 1'b0, 32'd1);
        send_request(CMD_EVENT, 7'd127, 7'd127, 1'b0, 32'hFFFF_FFFF);
        // Time wraps round: the gap here is one tick.
        send_request(CMD_EVENT, 7'd127, 7'd127, 1'b1, 32'd0);
    endtask

    // Decay, read and clear each address a pixel through the same row flip.
    task automatic test_commands();
        req_idle_on  = 1'b1;
        resp_idle_on = 1'b1;
        send_request(CMD_DECAY, 7'd127, 7'd127, 1'b1, 32'h5A5A_5A5A);
        send_request(CMD_READ, 7'd127, 7'd0, 1'b0, 32'd0);
        send_request(CMD_CLEAR, 7'd3, 7'd4, 1'b1, 32'd0);
        send_request(CMD_READ, 7'd127, 7'd127, 1'b0, 32'd0);
        send_request(CMD_EVENT, 7'd64, 7'd1, 1'b0, 32'h8000_0000);
        send_request(CMD_DECAY, 7'd64, 7'd1, 1'b0, 32'd0);
        send_request(CMD_READ, 7'd64, 7'd1, 1'b1, 32'hFFFF_FFFF);
    endtask

    // Registers at their limits: zero and full step, zero and full refractory gap.
    task automatic test_register_extremes();
        configure(32'd0, 8'd0, 24'hA5C3F0, 24'h5A3C0F, 24'hFFFFFF, 1'b0);
        send_request(CMD_EVENT, 7'd0, 7'd127, 1'b1, 32'd7);
        send_request(CMD_EVENT, 7'd127, 7'd0, 1'b0, 32'd7);
        // A zero step leaves every colour where it is.
        send_request(CMD_DECAY, 7'd0, 7'd127, 1'b0, 32'd0);
        send_request(CMD_READ, 7'd127, 7'd0, 1'b0, 32'd0);
        // No gap can exceed the largest interval.
        configure(32'hFFFF_FFFF, 8'd255, 24'hFFFFFF, 24'h000000, 24'h7F00FF, 1'b1);
        send_request(CMD_EVENT, 7'd5, 7'd5, 1'b1, 32'h1234_5678);
        configure(32'd0, 8'd255, 24'hFFFFFF, 24'h000000, 24'h7F00FF, 1'b1);
        send_request(CMD_EVENT, 7'd5, 7'd5, 1'b1, 32'h1234_5678);
        send_request(CMD_EVENT, 7'd6, 7'd5, 1'b0, 32'h1234_5678);
        send_request(CMD_DECAY, 7'd5, 7'd5, 1'b0, 32'd0);
        send_request(CMD_READ, 7'd6, 7'd5, 1'b0, 32'd0);
    endtask

    // The result side holds off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        drain_results();
        req_idle_on  = 1'b0;
        hold_off_req = 1'b1;
        for (int i = 0; i < 16; i++) begin
            send_request(i[0] ? CMD_READ : CMD_EVENT, i[6:0], 7'(i * 9), i[1],
                         32'(i * 1000 + 50));
        end
        drain_results();
    endtask

    // Phases of random traffic, mostly events on a small set of pixels so that the
    // refractory test sees both verdicts, with stray pixels and random times mixed in.
    task automatic test_random_traffic();
        logic [POS_BITS-1:0]  pool_x [16];
        logic [POS_BITS-1:0]  pool_y [16];
        logic [REFR_BITS-1:0] refr;
        logic [STEP_BITS-1:0] step;
        t_color               on_c;
        t_color               off_c;
        t_color               mid_c;
        logic [CMD_BITS-1:0]  cmd;
        logic [POS_BITS-1:0]  px;
        logic [POS_BITS-1:0]  py;
        t_time                ts;
        t_time                now_ticks;
        int                   r;
        int                   slot;
        int                   pass_count;
        pass_count = 0;
        for (int phase = 0; phase < 4; phase++) begin
            on_c  = COLOR_BITS'($urandom);
            off_c = COLOR_BITS'($urandom);
            mid_c = COLOR_BITS'($urandom);
            step  = STEP_BITS'($urandom_range(1, 40));
            case (phase)
                0: begin
                    refr  = 32'd150;
                    step  = 8'd4;
                    on_c  = 24'hFFFFFF;
                    off_c = 24'h000000;
                    mid_c = 24'h808080;
                end
                1: refr = $urandom_range(0, 63);
                2: begin
                    refr = 32'd0;
                    step = 8'd255;
                end
                default: refr = $urandom_range(500, 4000);
            endcase
            configure(refr, step, on_c, off_c, mid_c, ~phase[0]);

            // The corners are always in the pool.
            for (int i = 0; i < 16; i++) begin
                pool_x[i] = POS_BITS'($urandom);
                pool_y[i] = POS_BITS'($urandom);
            end
            pool_x[0] = 7'd0;   pool_y[0] = 7'd0;
            pool_x[1] = 7'd127; pool_y[1] = 7'd127;
            pool_x[2] = 7'd0;   pool_y[2] = 7'd127;
            pool_x[3] = 7'd127; pool_y[3] = 7'd0;
            now_ticks = $urandom;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 100 == 0) begin
                    req_idle_on  = ($urandom_range(0, 3) != 0);
                    resp_idle_on = ($urandom_range(0, 3) != 0);
                end
                slot = $urandom_range(0, 15);
                px = pool_x[slot];
                py = pool_y[slot];
                if ($urandom_range(0, 9) == 0) begin
                    px = POS_BITS'($urandom);
                    py = POS_BITS'($urandom);
                end
                now_ticks += $urandom_range(0, refr / 8 + 2);
                ts = ($urandom_range(0, 19) == 0) ? t_time'($urandom) : now_ticks;
                // Full-map passes are slow, so only a bounded number of them.
                r = $urandom_range(0, 999);
                if (r < 12 && pass_count < MAX_PASSES) begin
                    cmd = CMD_DECAY;
                    pass_count++;
                end else if (r < 16 && pass_count < MAX_PASSES) begin
                    cmd = CMD_CLEAR;
                    pass_count++;
                end else if (r < 250) begin
                    cmd = CMD_READ;
                end else begin
                    cmd = CMD_EVENT;
                end
                send_request(cmd, px, py, 1'($urandom), ts);
            end
        end
    endtask

    // Result side: random stalls, or one long hold-off when a test asks for it.
    initial begin
        int span;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                span = HOLD_CYCLES;
            end else if (resp_idle_on) begin
                span = pick_gap();
                i_out_stall <= (span > 0);
                if (span == 0) span = $urandom_range(1, 4);
            end else begin
                i_out_stall <= 1'b0;
                span = 1;
            end
            repeat (span) @(posedge i_clk);
        end
    end

    // Compares each taken result with the oldest prediction.
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result: red %0h green %0h blue %0h accepted %0b",
                       o_red, o_green, o_blue, o_accepted);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_red !== want.red) begin
                    $error("red: expected %0h, got %0h", want.red, o_red);
                    error_count++;
                end
                if (o_green !== want.green) begin
                    $error("green: expected %0h, got %0h", want.green, o_green);
                    error_count++;
                end
                if (o_blue !== want.blue) begin
                    $error("blue: expected %0h, got %0h", want.blue, o_blue);
                    error_count++;
                end
                if (o_accepted !== want.accepted) begin
                    $error("accepted: expected %0b, got %0b", want.accepted, o_accepted);
                    error_count++;
                end
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_REFRACTORY;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_cmd       <= CMD_READ;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_polarity  <= 1'b0;
        i_timestamp <= '0;

        // Predicted state after reset: black map, all times zero.
        refr_gap  = RST_REFRACTORY;
        step_size = RST_DECAY_STEP;
        on_rgb    = RST_ON_COLOR;
        off_rgb   = RST_OFF_COLOR;
        rest_rgb  = RST_MID_COLOR;
        flip_rows = RST_FLIP;
        for (int i = 0; i < CELLS; i++) begin
            color_map[i] = '0;
            stamp_map[i] = '0;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_clear();
        test_commands();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== event_pixel_map_with_refractory_decay_top.f =====
src/evpm_pkg.sv
src/event_pixel_map_with_refractory_decay_top.sv
verif/tb_event_pixel_map_with_refractory_decay_top.sv
